FILE: rtl/core/lebuf_pkg.sv
// shared types and constants for the line edit buffer
package lebuf_pkg;

   localparam int POS_W    = 13;
   localparam int RD_IDX_W = 7;
   localparam int CHAR_W   = 8;
   localparam int GROUP_N  = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_MOVE   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef struct packed {
      logic              ins;
      logic              del;
      logic [POS_W-1:0]  pos;
      logic [CHAR_W-1:0] ch;
   } edit_type;

   typedef struct packed {
      logic                en;
      logic [RD_IDX_W-1:0] idx;
   } read_type;

   typedef struct packed {
      logic [8:0] count;
      logic [7:0] cursor_pos;
      logic [7:0] line_length;
      logic       full_res;
   } result_type;

endpackage

FILE: rtl/core/lebuf_cell.sv
// one character cell of the shifting line store
module lebuf_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                        clock,
   input  lebuf_pkg::edit_type         edit,
   input  lebuf_pkg::read_type         rd,
   input  logic [lebuf_pkg::CHAR_W-1:0] left_data,
   input  logic [lebuf_pkg::CHAR_W-1:0] right_data,
   output logic [lebuf_pkg::CHAR_W-1:0] data,
   output logic [lebuf_pkg::CHAR_W-1:0] rd_data
);

   localparam logic [lebuf_pkg::POS_W-1:0] MY_POS  = lebuf_pkg::POS_W'(CELL_IDX);
   localparam logic [lebuf_pkg::POS_W:0]   MY_NEXT = (lebuf_pkg::POS_W + 1)'(CELL_IDX + 1);

   logic [lebuf_pkg::CHAR_W-1:0] data_ff;
   logic [lebuf_pkg::CHAR_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (edit.ins) begin
         if (MY_POS == edit.pos) begin
            data_in = edit.ch;
         end else if (MY_POS > edit.pos) begin
            data_in = left_data;
         end
      end else if (edit.del) begin
         if (MY_NEXT >= {1'b0, edit.pos}) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (rd.en && (MY_POS == lebuf_pkg::POS_W'(rd.idx))) ? data_ff : '0;

endmodule

FILE: rtl/core/line_edit_buffer.sv
// line edit buffer top level: cursor and length control, cell row, read-out tree
// Usage:
//   req_ channel takes one command word: req_tuser carries the opcode
//   (insert, delete, move, read), req_tdata the byte, offset and read index.
//   rsp_ channel returns exactly one word per command with the count,
//   cursor, length, read byte and full flag after that command.
//   Insert and delete shift the whole tail through the row of character
//   cells in the accepting cycle; cursor and length update in the same edge.
//   A read goes through a two-level registered OR tree over the cells
//   (16 cells per group); every result passes the s1 and s2 stages and
//   the output register after its command is accepted.
//   One command is in the tree at a time: a new word is taken only once
//   the previous one has left the s1 and s2 stages, so no new command
//   enters before the last one is through the read-out tree.
//   When rsp_tready is low the result holds in the output register, one
//   more command may enter and wait in the tree, then req_tready stays low.
//   Reset clears cursor, length and all valid flags; character cells are
//   not cleared, bytes at or beyond the length are never returned.
module line_edit_buffer #(
   parameter int CAPACITY = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // ch[7:0], offset[16:8], read_index[23:17]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // count[8:0], cursor_pos[16:9], line_length[24:17],
                                    // read_char[32:25], full_res[33]
);

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int MW     = ((CW > 9) ? CW : 9) + 1;
   localparam int NGROUP = (CAPACITY + lebuf_pkg::GROUP_N - 1) / lebuf_pkg::GROUP_N;
   localparam int NPAD   = NGROUP * lebuf_pkg::GROUP_N;
   localparam logic [CW-1:0] CAP_VAL = CW'(CAPACITY);

   lebuf_pkg::op_type opcode;
   logic [7:0]  req_ch;
   logic [8:0]  req_offset;
   logic [6:0]  req_read_index;
   logic        accept;

   logic [CW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] length_ff, length_in;
   logic [8:0]    count_in;

   logic [MW-1:0] off_ext, want, room, mv_pos, mv_neg;
   logic [MW-1:0] neg_cnt;

   lebuf_pkg::edit_type   edit;
   lebuf_pkg::read_type   rd_in, rd_ff;
   lebuf_pkg::result_type res_in, s1_res_ff, s2_res_ff;

   logic s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic s2_move;
   logic [39:0] out_data_ff;

   logic [lebuf_pkg::POS_W-1:0] cur_ext, len_ext;

   logic [lebuf_pkg::CHAR_W-1:0] cell_data [CAPACITY];
   logic [lebuf_pkg::CHAR_W-1:0] rd_bus    [NPAD];
   logic [lebuf_pkg::CHAR_W-1:0] grp_in    [NGROUP];
   logic [lebuf_pkg::CHAR_W-1:0] grp_ff    [NGROUP];
   logic [lebuf_pkg::CHAR_W-1:0] rchar;

   assign opcode         = lebuf_pkg::op_type'(req_tuser);
   assign req_ch         = req_tdata[7:0];
   assign req_offset     = req_tdata[16:8];
   assign req_read_index = req_tdata[23:17];

   assign req_tready = !s1_valid_ff && !s2_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // move arithmetic
   assign off_ext = {{(MW - 9){req_offset[8]}}, req_offset};
   assign want    = MW'(0) - off_ext;
   assign room    = MW'(length_ff) - MW'(cursor_ff);
   assign mv_pos  = (off_ext < room) ? off_ext : room;
   assign mv_neg  = (want < MW'(cursor_ff)) ? want : MW'(cursor_ff);
   assign neg_cnt = MW'(0) - mv_neg;

   always_comb begin
      cursor_in = cursor_ff;
      length_in = length_ff;
      count_in  = '0;
      edit.ins  = 1'b0;
      edit.del  = 1'b0;
      edit.pos  = lebuf_pkg::POS_W'(cursor_ff);
      edit.ch   = req_ch;
      rd_in.en  = 1'b0;
      rd_in.idx = req_read_index;
      case (opcode)
         lebuf_pkg::OP_INSERT: begin
            if (length_ff < CAP_VAL) begin
               edit.ins  = accept;
               cursor_in = cursor_ff + CW'(1);
               length_in = length_ff + CW'(1);
               count_in  = 9'd1;
            end
         end
         lebuf_pkg::OP_DELETE: begin
            if (cursor_ff != '0) begin
               edit.del  = accept;
               cursor_in = cursor_ff - CW'(1);
               length_in = length_ff - CW'(1);
               count_in  = 9'd1;
            end
         end
         lebuf_pkg::OP_MOVE: begin
            if (!req_offset[8] && req_offset != '0) begin
               cursor_in = cursor_ff + mv_pos[CW-1:0];
               count_in  = mv_pos[8:0];
            end else if (req_offset[8]) begin
               cursor_in = cursor_ff - mv_neg[CW-1:0];
               count_in  = neg_cnt[8:0];
            end
         end
         lebuf_pkg::OP_READ: begin
            rd_in.en = lebuf_pkg::POS_W'(req_read_index) < lebuf_pkg::POS_W'(length_ff);
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   assign cur_ext = lebuf_pkg::POS_W'(cursor_in);
   assign len_ext = lebuf_pkg::POS_W'(length_in);

   always_comb begin
      res_in.count       = count_in;
      res_in.cursor_pos  = cur_ext[7:0];
      res_in.line_length = len_ext[7:0];
      res_in.full_res    = (length_in == CAP_VAL);
   end

   // row of character cells
   for (genvar i = 0; i < NPAD; i++) begin : g_cell
      if (i < CAPACITY) begin : g_real
         logic [lebuf_pkg::CHAR_W-1:0] left_d, right_d;
         if (i == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid_l
            assign left_d = cell_data[i - 1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_d = cell_data[i + 1];
         end
         lebuf_cell #(.CELL_IDX(i)) u_cell (
            .clock      (clock),
            .edit       (edit),
            .rd         (rd_ff),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (rd_bus[i])
         );
      end else begin : g_pad
         assign rd_bus[i] = '0;
      end
   end

   // read-out tree, group level then final level
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < lebuf_pkg::GROUP_N; k++) begin
            grp_in[g] = grp_in[g] | rd_bus[g * lebuf_pkg::GROUP_N + k];
         end
      end
   end

   always_comb begin
      rchar = '0;
      for (int g = 0; g < NGROUP; g++) begin
         rchar = rchar | grp_ff[g];
      end
   end

   assign s2_move = s2_valid_ff && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         length_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            cursor_ff <= cursor_in;
            length_ff <= length_in;
         end
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= res_in;
         rd_ff     <= rd_in;
      end
      if (s1_valid_ff) begin
         s2_res_ff <= s1_res_ff;
         grp_ff    <= grp_in;
      end
      if (s2_move) begin
         out_data_ff <= {6'b0, s2_res_ff.full_res, rchar, s2_res_ff.line_length,
                         s2_res_ff.cursor_pos, s2_res_ff.count};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTH
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond line length");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= CAP_VAL)
      else $error("line length beyond capacity");

   a_tree_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> s2_valid_ff)
      else $error("read-out stage lost a word");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == lebuf_pkg::OP_INSERT && length_ff < CAP_VAL
      |=> length_ff == $past(length_ff) + CW'(1))
      else $error("insert did not grow the line");

   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("two words in the read-out tree");
`endif

endmodule

FILE: sim/line_edit_buffer_tb.sv
// self-checking testbench for the line edit buffer: random edit streams against a cursor model
`timescale 1ns / 100ps

module line_edit_buffer_tb;

   localparam int LINE_CAP   = 128;
   localparam int EDIT_COUNT = 1500;
   localparam int IDLE_PCT   = 32;
   localparam int STALL_MAX  = 3000;
   localparam int TAIL_WAIT  = 10;

   typedef struct packed {
      lebuf_pkg::op_type op;
      logic [7:0]        ch;
      logic signed [8:0] offset;
      logic [6:0]        ridx;
   } edit_cmd_type;

   typedef struct packed {
      logic [8:0] count;
      logic [7:0] cursor_pos;
      logic [7:0] line_length;
      logic [7:0] read_char;
      logic       full;
   } line_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // ch[7:0], offset[16:8], read_index[23:17]
   logic [1:0]  req_tuser = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // count[8:0], cursor_pos[16:9], line_length[24:17],
                                  // read_char[32:25], full_res[33]

   edit_cmd_type    edits_q[$];
   line_status_type status_q[$];
   edit_cmd_type    on_bus;
   logic [7:0]      line_buf[0:LINE_CAP-1];
   int              line_cur = 0;
   int              line_len = 0;
   int              edits_sent = 0;
   int              stall_cycles = 0;
   int              errors = 0;
   wire             steady = edits_sent >= 600 && edits_sent < 900;

   line_edit_buffer #(.CAPACITY(LINE_CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic line_status_type apply_edit(edit_cmd_type c);
      line_status_type r;
      int              i;
      int              off;
      int              mv;
      int              moved;
      r = '0;
      moved = 0;
      off = c.offset;
      case (c.op)
         lebuf_pkg::OP_INSERT: begin
            if (line_len < LINE_CAP) begin
               for (i = line_len; i > line_cur; i--) line_buf[i] = line_buf[i-1];
               line_buf[line_cur] = c.ch;
               line_cur++;
               line_len++;
               moved = 1;
            end
         end
         lebuf_pkg::OP_DELETE: begin
            if (line_cur > 0) begin
               for (i = line_cur - 1; i + 1 < line_len; i++) line_buf[i] = line_buf[i+1];
               line_cur--;
               line_len--;
               moved = 1;
            end
         end
         lebuf_pkg::OP_MOVE: begin
            if (off > 0) begin
               mv = (off < line_len - line_cur) ? off : line_len - line_cur;
               line_cur += mv;
               moved = mv;
            end else if (off < 0) begin
               mv = (-off < line_cur) ? -off : line_cur;
               line_cur -= mv;
               moved = -mv;
            end
         end
         default: begin
            if (c.ridx < line_len) r.read_char = line_buf[c.ridx];
         end
      endcase
      r.count       = moved[8:0];
      r.cursor_pos  = line_cur[7:0];
      r.line_length = line_len[7:0];
      r.full        = line_len == LINE_CAP;
      return r;
   endfunction

   function automatic edit_cmd_type make_edit(lebuf_pkg::op_type op, int arg);
      edit_cmd_type c;
      c.op     = op;
      c.ch     = 8'($urandom);
      c.offset = 9'($urandom_range(0, 256) - 128);
      c.ridx   = 7'($urandom);
      if (op == lebuf_pkg::OP_INSERT) c.ch = arg[7:0];
      if (op == lebuf_pkg::OP_MOVE) c.offset = arg[8:0];
      if (op == lebuf_pkg::OP_READ) c.ridx = arg[6:0];
      return c;
   endfunction

   function automatic edit_cmd_type random_edit(lebuf_pkg::op_type op);
      int arg;
      case (op)
         lebuf_pkg::OP_MOVE: arg = $urandom_range(0, 1) ? $urandom_range(0, 16) - 8
                                                        : $urandom_range(0, 256) - 128;
         lebuf_pkg::OP_READ: arg = $urandom_range(0, 1) ? $urandom_range(0, 15)
                                                        : $urandom_range(0, 127);
         default: arg = $urandom_range(0, 255);
      endcase
      return make_edit(op, arg);
   endfunction

   // typing until the line overflows, erasing from the end, or a loose mix
   task automatic push_burst(int kind);
      int                n;
      int                j;
      int                pick;
      lebuf_pkg::op_type op;
      if (kind < 2) begin
         n = $urandom_range(130, 150);
         for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0) edits_q.push_back(random_edit(lebuf_pkg::OP_READ));
            else edits_q.push_back(random_edit(lebuf_pkg::OP_INSERT));
         end
      end else if (kind < 4) begin
         edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, 128));
         n = $urandom_range(60, 140);
         for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0) edits_q.push_back(random_edit(lebuf_pkg::OP_READ));
            else edits_q.push_back(random_edit(lebuf_pkg::OP_DELETE));
         end
      end else begin
         n = $urandom_range(20, 60);
         for (j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) op = lebuf_pkg::OP_INSERT;
            else if (pick < 55) op = lebuf_pkg::OP_DELETE;
            else if (pick < 80) op = lebuf_pkg::OP_MOVE;
            else op = lebuf_pkg::OP_READ;
            edits_q.push_back(random_edit(op));
         end
      end
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            status_q.push_back(apply_edit(on_bus));
            edits_sent <= edits_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (edits_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               on_bus = edits_q.pop_front();
               req_tdata  <= {on_bus.ridx, on_bus.offset, on_bus.ch};
               req_tuser  <= on_bus.op;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      line_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %0h", $time, rsp_tdata);
               errors++;
            end else begin
               want = status_q.pop_front();
               check_field("count", want.count, rsp_tdata[8:0]);
               check_field("cursor_pos", want.cursor_pos, rsp_tdata[16:9]);
               check_field("line_length", want.line_length, rsp_tdata[24:17]);
               check_field("read_char", want.read_char, rsp_tdata[32:25]);
               check_field("full_res", want.full, rsp_tdata[33]);
               check_field("padding", 0, rsp_tdata[39:34]);
            end
         end
         rsp_tready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // empty line, clamps at both ends, byte extremes, edits at start, middle and end
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_DELETE, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, -128));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, 128));
      edits_q.push_back(make_edit(lebuf_pkg::OP_INSERT, 8'h00));
      edits_q.push_back(make_edit(lebuf_pkg::OP_INSERT, 8'hff));
      edits_q.push_back(make_edit(lebuf_pkg::OP_INSERT, 8'ha5));
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 1));
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 2));
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 127));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, -128));
      edits_q.push_back(make_edit(lebuf_pkg::OP_DELETE, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_INSERT, 8'h5a));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, 1));
      edits_q.push_back(make_edit(lebuf_pkg::OP_DELETE, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, 128));
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 3));
      edits_q.push_back(make_edit(lebuf_pkg::OP_DELETE, 0));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, -1));
      edits_q.push_back(make_edit(lebuf_pkg::OP_MOVE, 2));
      edits_q.push_back(make_edit(lebuf_pkg::OP_READ, 1));
      push_burst(0);
      while (edits_q.size() < EDIT_COUNT) push_burst($urandom_range(0, 9));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (edits_q.size() != 0 || req_tvalid || status_q.size() != 0) @(negedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
